// ----- rtl/text_console_cursor_scroll_macros.svh -----
// assertion macros for the text console engine
// used by rtl/text_console_cursor_scroll.sv, expects clk_i and rst_ni in scope
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// property holds at every rising clock edge outside reset
`define TCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition never seen at a rising clock edge outside reset
`define TCCS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/tccs_pkg.sv -----
// shared types, codes and cell helpers for the text console engine
// no dependencies
`timescale 1ns / 1ps

package tccs_pkg;

  typedef logic [15:0] cell_t;

  // request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // control characters
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // blank in light gray on black, the store contents after reset
  localparam cell_t BLANK_RESET = 16'h0720;

  localparam int unsigned POS_W = 11;

  function automatic cell_t make_cell(logic [3:0] fg, logic [3:0] bg, logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

endpackage

// ----- rtl/tccs_cell_store.sv -----
// single write port, single read port cell store with registered read data
// uses tccs_pkg for the cell type
`timescale 1ns / 1ps

module tccs_cell_store #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  tccs_pkg::cell_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output tccs_pkg::cell_t rdata_o
);

  tccs_pkg::cell_t mem_q [DEPTH];
  tccs_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/text_console_cursor_scroll.sv -----
// text console engine top level: cursor, scroll and clear sequencer
// depends on tccs_pkg, tccs_cell_store and text_console_cursor_scroll_macros.svh
`timescale 1ns / 1ps

// Text-mode console engine. It holds SCREEN_WIDTH x SCREEN_HEIGHT character cells
// (attribute high byte, character low byte) and a cursor. An item is taken when start_i
// is high and busy_o is low; each item gives exactly one result, shown for one cycle
// with done_o high. The receiver cannot stall: a result must be taken in the cycle it
// appears. Steps, from the accepting edge to the result cycle:
//   put of a printable, return, backspace or newline without scroll, unknown request:
//     the result is registered at the accepting edge, and the next item can be taken
//     in the result cycle
//   read of one cell: registered read of the cell store, then the registered result
//   clear screen: one cell written per cycle over the whole store, then the result cycle
//   newline or line wrap on the last row: each row-up copy is a read state (ST_SC_RD)
//     and a write state (ST_SC_WR), since the fetched cell is only there in the cycle
//     after its read; then the last row is blanked, then the result cycle
// In all these cases busy_o drops in the result cycle, so the next item can be taken
// there. After reset the store is swept to blanks with busy_o high. These sequences
// are set by the cell store, which does one read and one write per cycle, and the one
// address counter that walks it. Color registers may be written at any time the block
// is idle; cfg_ready_o is always high.

`include "text_console_cursor_scroll_macros.svh"

module text_console_cursor_scroll #(
  parameter int unsigned SCREEN_WIDTH  = 80,
  parameter int unsigned SCREEN_HEIGHT = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     req_type_i,
  input  logic [7:0]                     char_code_i,
  input  logic [10:0]                    cell_address_i,
  // result channel
  output logic                           done_o,
  output logic [10:0]                    cursor_position_o,
  output logic [15:0]                    read_data_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [3:0]                     cfg_data_i
);

  localparam int unsigned CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned CELL_AW    = $clog2(CELL_COUNT);
  localparam int unsigned ROW_W      = $clog2(SCREEN_HEIGHT);
  localparam int unsigned COL_W      = $clog2(SCREEN_WIDTH);
  // wide enough for any linear index, the cell count itself and the 11-bit ports
  localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int unsigned LIN_W      = (CNT_W > tccs_pkg::POS_W) ? CNT_W : tccs_pkg::POS_W;

  localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [CELL_AW-1:0] ROW_STEP  = CELL_AW'(SCREEN_WIDTH);
  localparam logic [CELL_AW-1:0] LAST_COPY = CELL_AW'(CELL_COUNT - SCREEN_WIDTH - 1);
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELL_COUNT - 1);
  localparam logic [LIN_W-1:0]   CELLS_LIN = LIN_W'(CELL_COUNT);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;  // cell read in flight
  localparam logic [2:0] ST_SC_RD = 3'd2;  // scroll: fetch the cell one row below
  localparam logic [2:0] ST_SC_WR = 3'd3;  // scroll: store it one row up
  localparam logic [2:0] ST_FILL  = 3'd4;  // blank cells from ptr to the end

  logic [2:0]         state_q, state_d;
  logic [CELL_AW-1:0] ptr_q, ptr_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               init_q, init_d;        // reset sweep, no result at its end
  logic               in_range_q, in_range_d;
  logic [3:0]         fg_q, bg_q;

  logic               done_q, done_d;
  logic [10:0]        pos_q;
  logic [15:0]        data_q, data_d;

  logic               accept;
  logic [LIN_W-1:0]   cur_lin, next_lin, rd_lin;
  logic [CELL_AW-1:0] cur_addr;
  tccs_pkg::cell_t    blank_cell;

  logic               mem_we, mem_re;
  logic [CELL_AW-1:0] mem_waddr, mem_raddr;
  tccs_pkg::cell_t    mem_wdata, mem_rdata;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign busy_o     = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // linear cursor index, row times width plus column
  assign cur_lin  = LIN_W'(row_q) * LIN_W'(SCREEN_WIDTH) + LIN_W'(col_q);
  assign next_lin = LIN_W'(row_d) * LIN_W'(SCREEN_WIDTH) + LIN_W'(col_d);
  assign cur_addr = cur_lin[CELL_AW-1:0];
  assign rd_lin   = LIN_W'(cell_address_i);

  assign blank_cell = tccs_pkg::make_cell(fg_q, bg_q, tccs_pkg::CH_SPACE);

  tccs_cell_store #(
    .DEPTH (CELL_COUNT),
    .AW    (CELL_AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    row_d      = row_q;
    col_d      = col_q;
    init_d     = init_q;
    in_range_d = in_range_q;
    done_d     = 1'b0;
    data_d     = '0;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = blank_cell;
    mem_re     = 1'b0;
    mem_raddr  = rd_lin[CELL_AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            tccs_pkg::REQ_PUT: begin
              unique case (char_code_i)
                tccs_pkg::CH_NEWLINE: begin
                  col_d = '0;
                  if (row_q != LAST_ROW) begin
                    row_d  = row_q + ROW_W'(1);
                    done_d = 1'b1;
                  end else begin
                    ptr_d   = '0;
                    state_d = ST_SC_RD;
                  end
                end
                tccs_pkg::CH_RETURN: begin
                  col_d  = '0;
                  done_d = 1'b1;
                end
                tccs_pkg::CH_BACKSPACE: begin
                  // at column zero nothing is erased
                  if (col_q != '0) begin
                    col_d     = col_q - COL_W'(1);
                    mem_we    = 1'b1;
                    mem_waddr = cur_addr - CELL_AW'(1);
                  end
                  done_d = 1'b1;
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_wdata = tccs_pkg::make_cell(fg_q, bg_q, char_code_i);
                  if (col_q == LAST_COL) begin
                    // wrap to the next line, scrolling on the last row
                    col_d = '0;
                    if (row_q != LAST_ROW) begin
                      row_d  = row_q + ROW_W'(1);
                      done_d = 1'b1;
                    end else begin
                      ptr_d   = '0;
                      state_d = ST_SC_RD;
                    end
                  end else begin
                    col_d  = col_q + COL_W'(1);
                    done_d = 1'b1;
                  end
                end
              endcase
            end
            tccs_pkg::REQ_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              ptr_d   = '0;
              state_d = ST_FILL;
            end
            tccs_pkg::REQ_READ: begin
              mem_re     = 1'b1;
              in_range_d = (rd_lin < CELLS_LIN);
              state_d    = ST_READ;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        data_d  = in_range_q ? mem_rdata : 16'd0;
        state_d = ST_IDLE;
      end
      ST_SC_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q + ROW_STEP;
        state_d   = ST_SC_WR;
      end
      ST_SC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = mem_rdata;
        ptr_d     = ptr_q + CELL_AW'(1);
        // after the last copy ptr points at the first cell of the last row
        state_d   = (ptr_q == LAST_COPY) ? ST_FILL : ST_SC_RD;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = init_q ? tccs_pkg::BLANK_RESET : blank_cell;
        if (ptr_q == LAST_CELL) begin
          done_d  = !init_q;
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + CELL_AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      ptr_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      init_q     <= 1'b1;
      in_range_q <= 1'b0;
      done_q     <= 1'b0;
      pos_q      <= '0;
      data_q     <= '0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      row_q      <= row_d;
      col_q      <= col_d;
      init_q     <= init_d;
      in_range_q <= in_range_d;
      done_q     <= done_d;
      pos_q      <= next_lin[10:0];
      data_q     <= data_d;
    end
  end

  // color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tccs_pkg::FG_RESET;
      bg_q <= tccs_pkg::BG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tccs_pkg::CFG_FOREGROUND: fg_q <= cfg_data_i;
        tccs_pkg::CFG_BACKGROUND: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign done_o            = done_q;
  assign cursor_position_o = pos_q;
  assign read_data_o       = data_q;

  // every item ends with the sequencer back at rest
  `TCCS_ASSERT(a_done_idle, done_q |-> (state_q == ST_IDLE), "result while sequencer busy")
  // read data only follows a cell read
  `TCCS_ASSERT(a_data_read, (done_q && (data_q != 16'd0)) |-> ($past(state_q) == ST_READ),
    "read data on a non-read result")
  // a scroll store always follows its fetch
  `TCCS_ASSERT(a_scroll_pair, (state_q == ST_SC_WR) |-> ($past(state_q) == ST_SC_RD),
    "scroll store without fetch")
  // idle writes come only from an accepted put
  `TCCS_ASSERT_NEVER(a_idle_write, mem_we && (state_q == ST_IDLE) && !accept,
    "cell write while idle without an item")

endmodule

// ----- verif/tccs_checker.sv -----
// checker for the text console engine: predicts every result from the accepted items
// and color writes, then compares each strobed result against the oldest prediction
// depends on tccs_pkg
`timescale 1ns / 1ps

module tccs_checker #(
  parameter int unsigned SCREEN_WIDTH  = 80,
  parameter int unsigned SCREEN_HEIGHT = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [1:0]                     req_type_i,
  input  logic [7:0]                     char_code_i,
  input  logic [10:0]                    cell_address_i,
  input  logic                           done_i,
  input  logic [10:0]                    cursor_position_i,
  input  logic [15:0]                    read_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [3:0]                     cfg_data_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);

  localparam int unsigned CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    logic [tccs_pkg::POS_W-1:0] cursor_position;
    tccs_pkg::cell_t            read_data;
  } console_result_t;

  tccs_pkg::cell_t screen_model [CELL_COUNT];
  logic [5:0]      row_q;
  // one bit above the widest line so the step past the line end is seen
  logic [7:0]      col_q;
  logic [3:0]      fg_q;
  logic [3:0]      bg_q;
  console_result_t console_expect_q [$];
  int unsigned     mismatches;

  function automatic tccs_pkg::cell_t colored_cell(logic [7:0] ch);
    return {bg_q, fg_q, ch};
  endfunction

  task automatic blank_screen();
    for (int unsigned i = 0; i < CELL_COUNT; i++)
      screen_model[i] = colored_cell(tccs_pkg::CH_SPACE);
  endtask

  // move to the next row, scrolling when already on the last one
  task automatic advance_row();
    col_q = '0;
    if (int'(row_q) + 1 < int'(SCREEN_HEIGHT)) begin
      row_q = row_q + 1'b1;
    end else begin
      for (int unsigned i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++)
        screen_model[i] = screen_model[i + SCREEN_WIDTH];
      for (int unsigned i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++)
        screen_model[i] = colored_cell(tccs_pkg::CH_SPACE);
      row_q = 6'(SCREEN_HEIGHT - 1);
    end
  endtask

  task automatic put_character(logic [7:0] ch);
    if (ch == tccs_pkg::CH_NEWLINE) begin
      advance_row();
    end else if (ch == tccs_pkg::CH_RETURN) begin
      col_q = '0;
    end else if (ch == tccs_pkg::CH_BACKSPACE) begin
      if (col_q != '0) begin
        col_q = col_q - 1'b1;
        screen_model[int'(row_q) * SCREEN_WIDTH + int'(col_q)] =
          colored_cell(tccs_pkg::CH_SPACE);
      end
    end else begin
      screen_model[int'(row_q) * SCREEN_WIDTH + int'(col_q)] = colored_cell(ch);
      col_q = col_q + 1'b1;
      if (int'(col_q) >= int'(SCREEN_WIDTH)) advance_row();
    end
  endtask

  task automatic console_item(input logic [1:0] req, input logic [7:0] ch,
                              input logic [10:0] addr, output console_result_t res);
    res.read_data = '0;
    case (req)
      tccs_pkg::REQ_PUT: put_character(ch);
      tccs_pkg::REQ_CLEAR: begin
        blank_screen();
        row_q = '0;
        col_q = '0;
      end
      tccs_pkg::REQ_READ: begin
        if (int'(addr) < int'(CELL_COUNT)) res.read_data = screen_model[addr];
      end
      default: ;
    endcase
    res.cursor_position = tccs_pkg::POS_W'(int'(row_q) * SCREEN_WIDTH + int'(col_q));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CELL_COUNT; i++) screen_model[i] = tccs_pkg::BLANK_RESET;
      row_q = '0;
      col_q = '0;
      fg_q = tccs_pkg::FG_RESET;
      bg_q = tccs_pkg::BG_RESET;
      console_expect_q.delete();
      mismatches = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      // results first: an item accepted at this edge cannot have its result yet
      if (done_i) begin
        if (console_expect_q.size() == 0) begin
          $error("unexpected result: cursor_position %0d read_data 0x%04h",
                 cursor_position_i, read_data_i);
          mismatches++;
        end else begin
          want = console_expect_q.pop_front();
          if (cursor_position_i !== want.cursor_position) begin
            $error("cursor_position: expected %0d, actual %0d",
                   want.cursor_position, cursor_position_i);
            mismatches++;
          end
          if (read_data_i !== want.read_data) begin
            $error("read_data: expected 0x%04h, actual 0x%04h", want.read_data, read_data_i);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          tccs_pkg::CFG_FOREGROUND: fg_q = cfg_data_i;
          tccs_pkg::CFG_BACKGROUND: bg_q = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        console_item(req_type_i, char_code_i, cell_address_i, want);
        console_expect_q.push_back(want);
      end
      pending_o <= console_expect_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ----- verif/testbench.sv -----
// top of the text console engine testbench: clock, reset, item and color stimulus, verdict
// depends on tccs_pkg, text_console_cursor_scroll and tccs_checker
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SCREEN_WIDTH  = 80;
  localparam int unsigned SCREEN_HEIGHT = 25;

  // request code the block does not know, answered with the cursor alone
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int unsigned ITEM_TARGET    = 750;
  // from here on the sender inserts no random gaps between items
  localparam int unsigned IDLE_FREE_FROM = 680;
  // settle time after the last result before touching colors
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES    = 20;
  // worst case is every item a scroll plus gaps, taken several times
  localparam int unsigned LIMIT_CYCLES   = 16_000_000;

  typedef enum logic [2:0] {
    SEQ_TEXT,
    SEQ_ERASE,
    SEQ_READS,
    SEQ_NEWLINES,
    SEQ_CLEAR,
    SEQ_NOISE,
    SEQ_RECOLOR
  } stim_seq_e;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [1:0]                     req_type;
  logic [7:0]                     char_code;
  logic [10:0]                    cell_address;
  logic                           done;
  logic [10:0]                    cursor_position;
  logic [15:0]                    read_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [3:0]                     cfg_data;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          seq_gaps;

  text_console_cursor_scroll #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .req_type_i       (req_type),
    .char_code_i      (char_code),
    .cell_address_i   (cell_address),
    .done_o           (done),
    .cursor_position_o(cursor_position),
    .read_data_o      (read_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  tccs_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_type_i       (req_type),
    .char_code_i      (char_code),
    .cell_address_i   (cell_address),
    .done_i           (done),
    .cursor_position_i(cursor_position),
    .read_data_i      (read_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hang guard
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // one item, entered and left at a falling edge; start is left high so that
  // back-to-back items keep it up without a dip
  task automatic send_item(input logic [1:0] req, input logic [7:0] ch,
                           input logic [10:0] addr);
    int unsigned gap;
    gap = 0;
    if (items_sent < IDLE_FREE_FROM && seq_gaps && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 5);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    req_type     <= req;
    char_code    <= ch;
    cell_address <= addr;
    // hold the item until the block takes it
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  // sender pause until every predicted result is back and the block is idle
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // both color registers back to back, only ever called on an idle block
  task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
    cfg_valid <= 1'b1;
    cfg_index <= tccs_pkg::CFG_FOREGROUND;
    cfg_data  <= fg;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= tccs_pkg::CFG_BACKGROUND;
    cfg_data  <= bg;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    stim_seq_e   seq_kind;
    int unsigned seq_idx;
    int unsigned roll;
    int unsigned len;
    logic [7:0]  ch;
    logic [10:0] addr;

    // every input known from time zero, reset held
    rst_n        = 1'b0;
    start        = 1'b0;
    req_type     = tccs_pkg::REQ_PUT;
    char_code    = '0;
    cell_address = '0;
    cfg_valid    = 1'b0;
    cfg_index    = tccs_pkg::CFG_FOREGROUND;
    cfg_data     = '0;
    items_sent   = 0;
    seq_gaps     = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block sweeps its store to blanks after reset
    do @(posedge clk); while (busy);
    @(negedge clk);

    // ---- directed part ----
    // reset contents at both ends of the store and reads past its end
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd0);
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd1999);
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd2000);
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'h7FF);
    // backspace at column zero erases nothing
    send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_BACKSPACE, 11'($urandom));
    send_item(tccs_pkg::REQ_PUT, 8'h41, 11'h7FF);
    // high character must not leak into the attribute
    send_item(tccs_pkg::REQ_PUT, 8'hFF, 11'd0);
    send_item(tccs_pkg::REQ_PUT, 8'h00, 11'($urandom));
    // backspace erases the cell just written
    send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_BACKSPACE, 11'($urandom));
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd2);
    send_item(tccs_pkg::REQ_READ, 8'hFF, 11'd1);
    send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_RETURN, 11'($urandom));
    send_item(REQ_UNKNOWN, 8'hFF, 11'h7FF);
    // colors at the top of their range touch only later cells
    wait_for_drain();
    write_colors(4'd15, 4'd15);
    send_item(tccs_pkg::REQ_PUT, 8'h5A, 11'($urandom));
    send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_NEWLINE, 11'($urandom));
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd0);
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd1);
    // colors at the bottom of their range, then a clear
    wait_for_drain();
    write_colors(4'd0, 4'd0);
    send_item(tccs_pkg::REQ_CLEAR, 8'($urandom), 11'($urandom));
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd1999);
    send_item(tccs_pkg::REQ_PUT, 8'h61, 11'($urandom));
    send_item(tccs_pkg::REQ_READ, 8'($urandom), 11'd0);

    // ---- random part: short sequences of well-formed console traffic ----
    seq_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      seq_gaps = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (seq_idx == 0) seq_kind = SEQ_NEWLINES;
      else if (seq_idx == 1) seq_kind = SEQ_TEXT;
      else if (roll < 42) seq_kind = SEQ_TEXT;
      else if (roll < 54) seq_kind = SEQ_ERASE;
      else if (roll < 70) seq_kind = SEQ_READS;
      else if (roll < 82) seq_kind = SEQ_NEWLINES;
      else if (roll < 86) seq_kind = SEQ_CLEAR;
      else if (roll < 93) seq_kind = SEQ_NOISE;
      else seq_kind = SEQ_RECOLOR;

      case (seq_kind)
        SEQ_TEXT: begin
          // a line of text: mostly short, some wrapping past the line end
          roll = $urandom_range(0, 99);
          if (seq_idx == 1 || roll >= 90) len = $urandom_range(80, 170);
          else if (roll >= 70) len = $urandom_range(16, 79);
          else len = $urandom_range(0, 15);
          repeat (len) begin
            if ($urandom_range(0, 9) == 0) ch = 8'($urandom_range(0, 255));
            else ch = 8'($urandom_range(32, 255));
            send_item(tccs_pkg::REQ_PUT, ch, 11'($urandom));
          end
          roll = $urandom_range(0, 9);
          if (roll >= 6 && roll <= 8)
            send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_RETURN, 11'($urandom));
          if (roll <= 7)
            send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_NEWLINE, 11'($urandom));
        end
        SEQ_ERASE: begin
          // long enough at times to run into column zero
          len = $urandom_range(1, 20);
          repeat (len) send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_BACKSPACE, 11'($urandom));
        end
        SEQ_READS: begin
          len = $urandom_range(1, 8);
          repeat (len) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) addr = 11'($urandom_range(2000, 2047));
            else if (roll == 1) begin
              case ($urandom_range(0, 3))
                0: addr = 11'd0;
                1: addr = 11'd1999;
                2: addr = 11'd2000;
                default: addr = 11'h7FF;
              endcase
            end else if (roll <= 4) addr = 11'($urandom_range(1920, 1999));
            else addr = 11'($urandom_range(0, 1999));
            send_item(tccs_pkg::REQ_READ, 8'($urandom), addr);
          end
        end
        SEQ_NEWLINES: begin
          // runs of newlines, long enough at times to reach the last row and scroll
          if (seq_idx == 0) len = 26;
          else len = $urandom_range(1, 26);
          repeat (len) send_item(tccs_pkg::REQ_PUT, tccs_pkg::CH_NEWLINE, 11'($urandom));
        end
        SEQ_CLEAR: begin
          send_item(tccs_pkg::REQ_CLEAR, 8'($urandom), 11'($urandom));
        end
        SEQ_NOISE: begin
          len = $urandom_range(1, 5);
          repeat (len) begin
            if ($urandom_range(0, 1) == 0) roll = 32'(REQ_UNKNOWN);
            else roll = $urandom_range(0, 3);
            send_item(2'(roll), 8'($urandom), 11'($urandom));
          end
        end
        default: begin
          // new colors, extremes now and then
          wait_for_drain();
          case ($urandom_range(0, 5))
            0: write_colors(4'd0, 4'd15);
            1: write_colors(4'd15, 4'd0);
            default: write_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
          endcase
        end
      endcase
      seq_idx++;
    end

    // ---- end of run ----
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tccs_pkg.sv
rtl/tccs_cell_store.sv
rtl/text_console_cursor_scroll.sv
verif/tccs_checker.sv
verif/testbench.sv
